// ===== hw/rtl/lfss_pkg.sv =====
package lfss_pkg;

   localparam int TIME_BITS_DEF = 32;

   localparam logic [11:0] LEN_PULSE  = 12'd2630;
   localparam logic [11:0] LEN_PLAIN  = 12'd1880;
   localparam logic [11:0] PULSE_FROM = 12'd1470;
   localparam logic [11:0] BLINK_FROM = 12'd2220;
   localparam logic [11:0] SKIP_SPAN  = 12'd750;

   localparam logic [7:0] REST_LEVEL = 8'd90;
   localparam logic [7:0] FULL_LEVEL = 8'd255;
   localparam logic [7:0] EYE_BASE   = 8'd220;
   localparam logic [7:0] STEP_LEVEL = 8'd15;

   localparam logic [31:0] MIX_K1 = 32'h7feb352d;
   localparam logic [31:0] MIX_K2 = 32'h846ca68b;

   localparam logic [9:0] CNUM_LAST = 10'd999;

   localparam logic CSR_DEAD_ZONE = 1'b0;
   localparam logic CSR_PULSE_GAP = 1'b1;

   typedef struct packed {
      logic        mode;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [7:0] eye_level;
      logic [1:0] mouth_level;
      logic [7:0] brightness_applied;
      logic       brightness_written;
      logic       cycle_wrapped;
      logic [9:0] cycle_number;
      logic       pulse_cycle;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_WRAP,
      ST_MIX1,
      ST_MIX2,
      ST_MIX3,
      ST_LOOK,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic capture;
      logic check;
      logic wrap;
      logic mix1;
      logic mix2;
      logic mix3;
      logic look;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic restart;
      logic wrap;
      logic need_hash;
      logic out_free;
   } status_type;

endpackage

// ===== hw/rtl/lfss_ctrl.sv =====
module lfss_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  lfss_pkg::status_type  status,
   output lfss_pkg::cmd_type     cmd
);

   lfss_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lfss_pkg::ST_IDLE: begin
            if (req_valid) state_in = lfss_pkg::ST_CHECK;
         end
         lfss_pkg::ST_CHECK: begin
            priority if (status.restart) state_in = lfss_pkg::ST_EMIT;
            else if (status.wrap) state_in = lfss_pkg::ST_WRAP;
            else state_in = lfss_pkg::ST_LOOK;
         end
         lfss_pkg::ST_WRAP: begin
            state_in = status.need_hash ? lfss_pkg::ST_MIX1 : lfss_pkg::ST_LOOK;
         end
         lfss_pkg::ST_MIX1: state_in = lfss_pkg::ST_MIX2;
         lfss_pkg::ST_MIX2: state_in = lfss_pkg::ST_MIX3;
         lfss_pkg::ST_MIX3: state_in = lfss_pkg::ST_LOOK;
         lfss_pkg::ST_LOOK: state_in = lfss_pkg::ST_EMIT;
         lfss_pkg::ST_EMIT: begin
            if (status.out_free) state_in = lfss_pkg::ST_IDLE;
         end
         default: state_in = lfss_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         lfss_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         lfss_pkg::ST_CHECK: cmd.check = 1'b1;
         lfss_pkg::ST_WRAP:  cmd.wrap  = 1'b1;
         lfss_pkg::ST_MIX1:  cmd.mix1  = 1'b1;
         lfss_pkg::ST_MIX2:  cmd.mix2  = 1'b1;
         lfss_pkg::ST_MIX3:  cmd.mix3  = 1'b1;
         lfss_pkg::ST_LOOK:  cmd.look  = 1'b1;
         lfss_pkg::ST_EMIT:  cmd.emit  = status.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lfss_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/lfss_dpath.sv =====
module lfss_dpath #(
   parameter int TIME_BITS = lfss_pkg::TIME_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lfss_pkg::req_type     req_item,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output lfss_pkg::rsp_type     rsp_item,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [7:0]            csr_wdata,
   input  lfss_pkg::cmd_type     cmd,
   output lfss_pkg::status_type  status
);

   function automatic logic [1:0] mouth_of(input logic [11:0] d);
      logic [1:0] m;
      priority if (d < 12'd41) m = 2'd1;
      else if (d < 12'd80) m = 2'd2;
      else if (d < 12'd340) m = 2'd3;
      else if (d < 12'd381) m = 2'd2;
      else if (d < 12'd420) m = 2'd1;
      else m = 2'd0;
      return m;
   endfunction

   function automatic logic [7:0] blink_of(input logic [11:0] d);
      logic [7:0] b;
      priority if (d < 12'd21) b = 8'd255;
      else if (d < 12'd41) b = 8'd127;
      else if (d < 12'd170) b = 8'd0;
      else if (d < 12'd190) b = 8'd127;
      else b = 8'd255;
      return b;
   endfunction

   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [TIME_BITS-1:0] start_ff, start_in;
   logic                 mode_ff, mode_in;
   logic                 pulse_ff, pulse_in;
   logic                 long_ff, long_in;
   logic [1:0]           cd_ff, cd_in;
   logic [31:0]          count_ff, count_in;
   logic [9:0]           cnum_ff, cnum_in;
   logic                 wrapped_ff, wrapped_in;
   logic [11:0]          phase_ff, phase_in;
   logic [31:0]          mix_ff, mix_in;
   logic [7:0]           eye_ff, eye_in;
   logic [1:0]           mouth_ff, mouth_in;
   logic [7:0]           bright_ff, bright_in;
   logic [7:0]           last_ff, last_in;
   logic [7:0]           dead_ff, dead_in;
   logic [1:0]           gap_ff, gap_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   lfss_pkg::rsp_type    rsp_ff, rsp_in;

   logic [63:0]          now_wide;
   logic [11:0]          len;
   logic [TIME_BITS-1:0] len_ext;
   logic [TIME_BITS-1:0] t_diff;
   logic                 wrap_hit;
   logic [31:0]          mix_y;
   logic                 hash_bit;
   logic [2:0]           gap_sum;
   logic [11:0]          look;
   logic [11:0]          seg_d;
   logic [10:0]          eye_x7;
   logic [23:0]          eye_prod;
   logic [9:0]           pls_d;
   logic [19:0]          pls_prod;
   logic [4:0]           pls_n;
   logic [7:0]           pls_step;
   logic [7:0]           pls_level;
   logic [7:0]           diff;

   assign now_wide = {32'd0, req_item.now_ms};
   assign len      = long_ff ? lfss_pkg::LEN_PULSE : lfss_pkg::LEN_PLAIN;
   assign len_ext  = {{(TIME_BITS - 12){1'b0}}, len};
   assign t_diff   = now_ff - start_ff;
   assign wrap_hit = (t_diff >= len_ext);

   assign mix_y    = mix_ff ^ (mix_ff >> 15);
   assign hash_bit = mix_ff[0] ^ mix_ff[16];
   assign gap_sum  = {1'b0, gap_ff} + {2'b00, hash_bit};

   assign look = (!pulse_ff && (phase_ff >= lfss_pkg::PULSE_FROM)) ?
                 phase_ff + lfss_pkg::SKIP_SPAN : phase_ff;
   assign seg_d = look - lfss_pkg::PULSE_FROM;

   assign eye_x7   = {3'b000, look[7:0]} * 11'd7;
   assign eye_prod = {13'd0, eye_x7} * 24'd2185;

   assign pls_d     = seg_d[9:0];
   assign pls_prod  = {10'd0, pls_d} * 20'd1311;
   assign pls_n     = pls_prod[19:15];
   assign pls_step  = {3'b000, pls_n} * lfss_pkg::STEP_LEVEL;

   always_comb begin
      priority if (pls_n < 5'd12) pls_level = lfss_pkg::REST_LEVEL + pls_step;
      else if (pls_n < 5'd24)
         pls_level = lfss_pkg::FULL_LEVEL - (pls_step - 8'd180);
      else pls_level = lfss_pkg::REST_LEVEL;
   end

   assign diff = (bright_ff > last_ff) ? bright_ff - last_ff : last_ff - bright_ff;

   assign status.restart   = mode_ff;
   assign status.wrap      = wrap_hit;
   assign status.need_hash = (cd_ff <= 2'd1);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      now_in       = now_ff;
      start_in     = start_ff;
      mode_in      = mode_ff;
      pulse_in     = pulse_ff;
      long_in      = long_ff;
      cd_in        = cd_ff;
      count_in     = count_ff;
      cnum_in      = cnum_ff;
      wrapped_in   = wrapped_ff;
      phase_in     = phase_ff;
      mix_in       = mix_ff;
      eye_in       = eye_ff;
      mouth_in     = mouth_ff;
      bright_in    = bright_ff;
      last_in      = last_ff;
      dead_in      = dead_ff;
      gap_in       = gap_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (csr_we) begin
         unique case (csr_index)
            lfss_pkg::CSR_DEAD_ZONE: dead_in = csr_wdata;
            lfss_pkg::CSR_PULSE_GAP: gap_in  = csr_wdata[1:0];
            default: ;
         endcase
      end

      if (cmd.capture) begin
         mode_in = req_item.mode;
         now_in  = now_wide[TIME_BITS-1:0];
      end

      if (cmd.check) begin
         wrapped_in = 1'b0;
         priority if (mode_ff) begin
            start_in = now_ff;
            pulse_in = 1'b1;
            long_in  = 1'b1;
            cd_in    = 2'd1;
            count_in = '0;
            cnum_in  = '0;
         end else if (wrap_hit) begin
            start_in   = start_ff + len_ext;
            count_in   = count_ff + 32'd1;
            cnum_in    = (cnum_ff == lfss_pkg::CNUM_LAST) ? 10'd0 : cnum_ff + 10'd1;
            wrapped_in = 1'b1;
         end else begin
            phase_in = t_diff[11:0];
         end
      end

      if (cmd.wrap) begin
         phase_in = wrap_hit ? 12'd0 : t_diff[11:0];
         mix_in   = count_ff ^ (count_ff >> 16);
         if (cd_ff > 2'd1) begin
            pulse_in = 1'b0;
            long_in  = 1'b0;
            cd_in    = cd_ff - 2'd1;
         end
      end

      if (cmd.mix1) mix_in = mix_ff * lfss_pkg::MIX_K1;
      if (cmd.mix2) mix_in = mix_y * lfss_pkg::MIX_K2;
      if (cmd.mix3) begin
         pulse_in = 1'b1;
         long_in  = 1'b1;
         cd_in    = (gap_sum > 3'd3) ? 2'd3 : gap_sum[1:0];
      end

      if (cmd.look) begin
         eye_in    = lfss_pkg::FULL_LEVEL;
         mouth_in  = 2'd0;
         bright_in = lfss_pkg::REST_LEVEL;
         priority if (look < 12'd430) begin
            if (look < 12'd150) eye_in = lfss_pkg::EYE_BASE + eye_prod[23:16];
         end else if (look < 12'd890) begin
            mouth_in = mouth_of(look - 12'd430);
         end else if (look < 12'd1010) begin
            mouth_in = 2'd0;
         end else if (look < lfss_pkg::PULSE_FROM) begin
            mouth_in = mouth_of(look - 12'd1010);
         end else if (look < lfss_pkg::BLINK_FROM) begin
            if (pulse_ff) bright_in = pls_level;
         end else begin
            eye_in = blink_of(look - lfss_pkg::BLINK_FROM);
         end
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         if (mode_ff) begin
            last_in                    = lfss_pkg::REST_LEVEL;
            rsp_in.eye_level           = lfss_pkg::FULL_LEVEL;
            rsp_in.mouth_level         = 2'd0;
            rsp_in.brightness_applied  = lfss_pkg::REST_LEVEL;
            rsp_in.brightness_written  = 1'b1;
            rsp_in.cycle_wrapped       = 1'b0;
            rsp_in.cycle_number        = '0;
            rsp_in.pulse_cycle         = 1'b1;
         end else begin
            if (diff >= dead_ff) last_in = bright_ff;
            rsp_in.eye_level           = eye_ff;
            rsp_in.mouth_level         = mouth_ff;
            rsp_in.brightness_applied  = (diff >= dead_ff) ? bright_ff : last_ff;
            rsp_in.brightness_written  = (diff >= dead_ff);
            rsp_in.cycle_wrapped       = wrapped_ff;
            rsp_in.cycle_number        = wrapped_ff ? cnum_ff : 10'd0;
            rsp_in.pulse_cycle         = pulse_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff     <= '0;
         pulse_ff     <= 1'b1;
         long_ff      <= 1'b0;
         cd_ff        <= 2'd1;
         count_ff     <= '0;
         cnum_ff      <= '0;
         last_ff      <= lfss_pkg::REST_LEVEL;
         dead_ff      <= 8'd3;
         gap_ff       <= 2'd2;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff     <= start_in;
         pulse_ff     <= pulse_in;
         long_ff      <= long_in;
         cd_ff        <= cd_in;
         count_ff     <= count_in;
         cnum_ff      <= cnum_in;
         last_ff      <= last_in;
         dead_ff      <= dead_in;
         gap_ff       <= gap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff     <= now_in;
      mode_ff    <= mode_in;
      wrapped_ff <= wrapped_in;
      phase_ff   <= phase_in;
      mix_ff     <= mix_in;
      eye_ff     <= eye_in;
      mouth_ff   <= mouth_in;
      bright_ff  <= bright_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// ===== hw/rtl/led_face_surprise_sequencer_unit.sv =====
// Each accepted item runs through check, then on a cycle wrap the wrap step and, when it
// reloads the pulse countdown through the hash, the mix steps, then lookup and emit;
// a restart goes from check straight to emit, and emit waits while a result is pending.
// The controller sequences one item at a time through the shared datapath.
// Reset (synchronous, active high): cycle anchor and count zero, cycle length 1880,
// countdown and pulse one, brightness 90, dead zone 3, pulse gap 2, no result pending.
module led_face_surprise_sequencer_unit #(
   parameter int TIME_BITS = lfss_pkg::TIME_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  lfss_pkg::req_type  req_item,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output lfss_pkg::rsp_type  rsp_item,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [7:0]         csr_wdata
);

   lfss_pkg::cmd_type    cmd;
   lfss_pkg::status_type status;

   lfss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lfss_dpath #(
      .TIME_BITS (TIME_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

`ifndef ASSERT_OFF
   a_one_cmd: assert property (@(posedge clock) disable iff (reset) $onehot0(cmd))
      else $error("more than one datapath command");

   a_cnum_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.cycle_wrapped |-> rsp_item.cycle_number == 10'd0)
      else $error("cycle number without wrap");

   a_cnum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.cycle_number <= lfss_pkg::CNUM_LAST)
      else $error("cycle number out of range");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !rsp_valid || rsp_ready)
      else $error("result overwritten while pending");
`endif

endmodule
